// ===== hw/rtl/dfir_pkg.sv =====
// shared constants, types and state codes of the decimating fir filter
package dfir_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 15;

  localparam int DEC_W   = 8;
  localparam int NTAPS_W = 7;
  localparam int TIDX_W  = 6;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = PROD_W + CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX    = 2'd2;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic push;
    logic load;
    logic clear;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic taps_zero;
    logic issue_last;
    logic pipe_empty;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/dfir_ram.sv =====
// generic single write port ram with registered read
module dfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dfir_ctrl.sv =====
// controller state machine sequencing loads, pushes and the tap loop
module dfir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  dfir_pkg::status_t status,
  output dfir_pkg::cmd_t    cmd
);

  dfir_pkg::state_t state_r;
  dfir_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfir_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dfir_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == dfir_pkg::FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.push = 1'b1;
            if (status.emit) begin
              cmd.clear = 1'b1;
              state_nxt = status.taps_zero ? dfir_pkg::ST_FINISH : dfir_pkg::ST_MAC;
            end
          end
        end
      end
      dfir_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = dfir_pkg::ST_DRAIN;
        end
      end
      dfir_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = dfir_pkg::ST_FINISH;
        end
      end
      dfir_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = dfir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dfir_pkg::ST_IDLE;
      end
    endcase
  end

  // result is only taken once every product has reached the accumulator
  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.pipe_empty)
    else $error("result loaded with products in flight");

  // the tap loop never leaves products behind when new beats are taken
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dfir_pkg::ST_IDLE) |-> status.pipe_empty)
    else $error("mac pipeline busy while idle");

  // loads and pushes only happen on an accepted input beat
  a_beat_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push || cmd.load) |-> (in_valid && in_ready))
    else $error("datapath command without an input beat");

endmodule

// ===== hw/rtl/dfir_datapath.sv =====
// datapath: config, delay line and tap memories, mac pipeline, output register
module dfir_datapath (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [dfir_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [dfir_pkg::CFG_W-1:0]                 cfg_data,
  input  logic signed [dfir_pkg::SAMPLE_BITS-1:0]    in_sample_re,
  input  logic signed [dfir_pkg::SAMPLE_BITS-1:0]    in_sample_im,
  input  logic [dfir_pkg::TIDX_W-1:0]                in_tap_index,
  input  logic signed [dfir_pkg::COEF_BITS-1:0]      in_tap_value,
  input  dfir_pkg::cmd_t                             cmd,
  output dfir_pkg::status_t                          status,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [dfir_pkg::SAMPLE_BITS-1:0]    out_re,
  output logic signed [dfir_pkg::SAMPLE_BITS-1:0]    out_im
);

  localparam int SB  = dfir_pkg::SAMPLE_BITS;
  localparam int AW  = dfir_pkg::TAP_AW;
  localparam int CW  = dfir_pkg::CNT_W;
  localparam int AC  = dfir_pkg::ACC_W;
  localparam int PW  = dfir_pkg::PROD_W;
  localparam int DW  = dfir_pkg::DEC_W;
  localparam logic signed [AC:0] RND    = (AC+1)'(1 << (dfir_pkg::FRAC_BITS - 1));
  localparam logic signed [AC:0] SAT_HI = (AC+1)'((1 << (SB - 1)) - 1);
  localparam logic signed [AC:0] SAT_LO = -SAT_HI - (AC+1)'(1);

  function automatic logic signed [SB-1:0] sat_round(input logic signed [AC-1:0] a);
    logic signed [AC:0] t;
    logic signed [AC:0] r;
    t = $signed({a[AC-1], a}) + RND;
    r = t >>> dfir_pkg::FRAC_BITS;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SB-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(dfir_pkg::MAX_TAPS - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(dfir_pkg::MAX_TAPS - 1) : p - AW'(1);
  endfunction

  // configuration
  logic [DW-1:0]                dec_r;
  logic [dfir_pkg::NTAPS_W-1:0] ntaps_r;
  logic                         cplx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r   <= DW'(1);
      ntaps_r <= dfir_pkg::NTAPS_W'(1);
      cplx_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfir_pkg::CFG_DECIMATION: dec_r   <= cfg_data[DW-1:0];
        dfir_pkg::CFG_NUM_TAPS:   ntaps_r <= cfg_data[dfir_pkg::NTAPS_W-1:0];
        dfir_pkg::CFG_COMPLEX:    cplx_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] n_taps;
  assign n_taps = (int'(ntaps_r) > dfir_pkg::MAX_TAPS) ? CW'(dfir_pkg::MAX_TAPS) : CW'(ntaps_r);

  // decimation phase
  logic [DW-1:0] phase_r;
  logic [DW-1:0] dec_eff;
  logic [DW:0]   phase_inc;
  logic [DW-1:0] phase_nxt;

  assign dec_eff   = (dec_r == '0) ? DW'(1) : dec_r;
  assign phase_inc = {1'b0, phase_r} + (DW+1)'(1);
  assign phase_nxt = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.push) begin
      phase_r <= phase_nxt;
    end
  end

  // delay line pointers and entry valid bits
  logic [AW-1:0]                 wp_r;
  logic [AW-1:0]                 rp_r;
  logic [AW-1:0]                 k_r;
  logic [dfir_pkg::MAX_TAPS-1:0] dvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      dvld_r <= '0;
    end else if (cmd.push) begin
      wp_r         <= ptr_inc(wp_r);
      dvld_r[wp_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      rp_r <= wp_r;
      k_r  <= '0;
    end else if (cmd.issue) begin
      rp_r <= ptr_dec(rp_r);
      k_r  <= k_r + AW'(1);
    end
  end

  // memories
  logic [2*SB-1:0]                   delay_wdata;
  logic [2*SB-1:0]                   delay_q;
  logic [dfir_pkg::COEF_BITS-1:0]    coef_q;
  logic                              coef_we;

  assign delay_wdata = {(cplx_r ? in_sample_im : SB'(0)), in_sample_re};
  assign coef_we     = cmd.load && (int'(in_tap_index) < dfir_pkg::MAX_TAPS);

  dfir_ram #(
    .WIDTH (2 * SB),
    .DEPTH (dfir_pkg::MAX_TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wp_r),
    .wdata (delay_wdata),
    .raddr (rp_r),
    .rdata (delay_q)
  );

  dfir_ram #(
    .WIDTH (dfir_pkg::COEF_BITS),
    .DEPTH (dfir_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(in_tap_index)),
    .wdata (in_tap_value),
    .raddr (k_r),
    .rdata (coef_q)
  );

  // mac pipeline: read, multiply, accumulate
  logic                  rd_vld_r;
  logic                  dv_q_r;
  logic                  prod_vld_r;
  logic signed [PW-1:0]  prod_re_r;
  logic signed [PW-1:0]  prod_im_r;
  logic signed [AC-1:0]  acc_re_r;
  logic signed [AC-1:0]  acc_im_r;
  logic signed [SB-1:0]  x_re;
  logic signed [SB-1:0]  x_im;

  // unwritten delay entries read as zero
  assign x_re = dv_q_r ? $signed(delay_q[SB-1:0])    : SB'(0);
  assign x_im = dv_q_r ? $signed(delay_q[2*SB-1:SB]) : SB'(0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    dv_q_r    <= dvld_r[rp_r];
    prod_re_r <= $signed(coef_q) * x_re;
    prod_im_r <= $signed(coef_q) * x_im;
    if (cmd.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (prod_vld_r) begin
      acc_re_r <= acc_re_r + AC'(prod_re_r);
      acc_im_r <= acc_im_r + AC'(prod_im_r);
    end
  end

  // output register
  logic                 out_valid_r;
  logic signed [SB-1:0] out_re_r;
  logic signed [SB-1:0] out_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_re_r <= sat_round(acc_re_r);
      out_im_r <= cplx_r ? sat_round(acc_im_r) : SB'(0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

  assign status.emit       = (phase_r == '0);
  assign status.taps_zero  = (n_taps == '0);
  assign status.issue_last = (CW'(k_r) == n_taps - CW'(1));
  assign status.pipe_empty = !rd_vld_r && !prod_vld_r;
  assign status.out_free   = !out_valid_r || out_ready;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output beat overwritten");

  // accumulator is cleared only by an emitting sample beat
  a_clear_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (cmd.push && status.emit))
    else $error("accumulator cleared outside a sample beat");

  // a pushed entry is marked as written from then on
  a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> dvld_r[$past(wp_r)])
    else $error("delay entry not marked after push");

endmodule

// ===== hw/rtl/decimating_fir_filter.sv =====
// Decimating FIR filter, real Q1.15 taps on real or complex 16-bit samples.
// A load beat (func 1) stores one tap. A sample beat (func 0) writes
// the sample into a circular delay memory; when the decimation phase is zero
// it also starts one shared multiply-accumulate unit (one multiplier per lane) that steps
// through the taps one per cycle out of the tap and delay memories, so an emitting sample
// occupies the block until its products are summed and the result is loaded, and only then is
// the next beat taken. Results sit in an output register, so the input is not held while
// a result waits unless a second result is ready to replace it. Outputs are rounded half up
// from the exact sum and saturated to 16 bits; out_im is zero in real mode. Load taps before
// pushing samples, and change the registers only while the block is idle.
module decimating_fir_filter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [dfir_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dfir_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_func,
  input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [dfir_pkg::SAMPLE_BITS-1:0] in_sample_im,
  input  logic [dfir_pkg::TIDX_W-1:0]             in_tap_index,
  input  logic signed [dfir_pkg::COEF_BITS-1:0]   in_tap_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [dfir_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [dfir_pkg::SAMPLE_BITS-1:0] out_im
);

  dfir_pkg::cmd_t    cmd;
  dfir_pkg::status_t status;

  dfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dfir_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_re       (out_re),
    .out_im       (out_im)
  );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the decimating fir filter: filter scoreboard, beat drivers, monitor
module testbench;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = dfir_pkg::MAX_TAPS + 16;
  localparam int RANDOM_ITEMS  = 620;
  localparam longint SMP_MAX   = (longint'(1) << (dfir_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN   = -SMP_MAX - 1;

  typedef logic signed [dfir_pkg::SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [dfir_pkg::COEF_BITS-1:0] tap_t;

  typedef struct {
    logic                        func;
    smp_t                        re;
    smp_t                        im;
    logic [dfir_pkg::TIDX_W-1:0] idx;
    tap_t                        tap;
  } fir_beat_t;

  typedef struct {
    smp_t re;
    smp_t im;
  } fir_out_t;

  class decim_fir_board;
    bit [dfir_pkg::DEC_W-1:0]              dec_reg   = 1;
    bit [dfir_pkg::NTAPS_W-1:0]            ntaps_reg = 1;
    bit                                    cplx_reg  = 0;
    bit signed [dfir_pkg::SAMPLE_BITS-1:0] hist_re [dfir_pkg::MAX_TAPS];
    bit signed [dfir_pkg::SAMPLE_BITS-1:0] hist_im [dfir_pkg::MAX_TAPS];
    tap_t                                  coef [dfir_pkg::MAX_TAPS];
    int                                    phase_cnt = 0;
    fir_out_t                              pending [$];
    int                                    mismatches = 0;

    function void set_reg(logic [dfir_pkg::CFG_IDX_W-1:0] idx,
                          logic [dfir_pkg::CFG_W-1:0] val);
      case (idx)
        dfir_pkg::CFG_DECIMATION: dec_reg = val[dfir_pkg::DEC_W-1:0];
        dfir_pkg::CFG_NUM_TAPS: ntaps_reg = val[dfir_pkg::NTAPS_W-1:0];
        dfir_pkg::CFG_COMPLEX: cplx_reg = val[0];
        default: ;
      endcase
    endfunction

    // round half up out of q15, then clamp
    function smp_t scale_q15(longint acc);
      longint q;
      q = (acc + (longint'(1) << (dfir_pkg::FRAC_BITS - 1))) >>> dfir_pkg::FRAC_BITS;
      if (q > SMP_MAX) q = SMP_MAX;
      else if (q < SMP_MIN) q = SMP_MIN;
      return q[dfir_pkg::SAMPLE_BITS-1:0];
    endfunction

    function void take_beat(fir_beat_t b);
      longint   acc_re;
      longint   acc_im;
      int       n;
      int       divisor;
      bit       emit;
      fir_out_t r;
      if (b.func == dfir_pkg::FUNC_LOAD) begin
        coef[b.idx] = b.tap;
        return;
      end
      for (int k = dfir_pkg::MAX_TAPS - 1; k > 0; k--) begin
        hist_re[k] = hist_re[k-1];
        hist_im[k] = hist_im[k-1];
      end
      hist_re[0] = b.re;
      hist_im[0] = cplx_reg ? b.im : '0;
      divisor = (dec_reg == 0) ? 1 : int'(dec_reg);
      emit = (phase_cnt == 0);
      phase_cnt = (phase_cnt + 1 >= divisor) ? 0 : phase_cnt + 1;
      if (!emit) return;
      n = (ntaps_reg > dfir_pkg::MAX_TAPS) ? dfir_pkg::MAX_TAPS : int'(ntaps_reg);
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < n; k++) begin
        acc_re += longint'(coef[k]) * longint'(hist_re[k]);
        acc_im += longint'(coef[k]) * longint'(hist_im[k]);
      end
      r.re = scale_q15(acc_re);
      r.im = cplx_reg ? scale_q15(acc_im) : '0;
      pending.push_back(r);
    endfunction

    function void check_output(smp_t re, smp_t im);
      fir_out_t exp_out;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual re %0d im %0d",
                 $time, re, im);
        return;
      end
      exp_out = pending.pop_front();
      if (exp_out.re !== re) begin
        mismatches++;
        $display("%0t: out_re mismatch, expected %0d actual %0d", $time, exp_out.re, re);
      end
      if (exp_out.im !== im) begin
        mismatches++;
        $display("%0t: out_im mismatch, expected %0d actual %0d", $time, exp_out.im, im);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [dfir_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dfir_pkg::CFG_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_func;
  smp_t                           in_sample_re;
  smp_t                           in_sample_im;
  logic [dfir_pkg::TIDX_W-1:0]    in_tap_index;
  tap_t                           in_tap_value;
  logic                           out_valid;
  logic                           out_ready;
  smp_t                           out_re;
  smp_t                           out_im;

  bit [dfir_pkg::MAX_TAPS-1:0] tap_loaded;
  bit                          idling = 1'b1;
  int                          cycle_count = 0;
  int                          stall_left = 0;
  decim_fir_board              board;

  decimating_fir_filter dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_output(out_re, out_im);
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && idling && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 9);
      out_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  function automatic smp_t any_sample();
    logic [31:0] r;
    r = $urandom;
    case (r[3:0])
      4'd0: return 16'h8000;
      4'd1: return 16'h7fff;
      4'd2: return 16'h0000;
      4'd3: return 16'hffff;
      default: return r[31:16];
    endcase
  endfunction

  // mostly small taps so that sums do not always clip
  function automatic tap_t any_tap();
    logic [31:0] r;
    r = $urandom;
    case (r[2:0])
      3'd0: return 16'h8000;
      3'd1: return 16'h7fff;
      3'd2: return r[31:16];
      default: return {{4{r[27]}}, r[27:16]};
    endcase
  endfunction

  function automatic fir_beat_t push_beat(smp_t re, smp_t im);
    fir_beat_t b;
    b.func = dfir_pkg::FUNC_PUSH;
    b.re   = re;
    b.im   = im;
    b.idx  = dfir_pkg::TIDX_W'($urandom_range(0, dfir_pkg::MAX_TAPS - 1));
    b.tap  = any_tap();
    return b;
  endfunction

  function automatic fir_beat_t load_beat(int idx, tap_t v);
    fir_beat_t b;
    b.func = dfir_pkg::FUNC_LOAD;
    b.re   = any_sample();
    b.im   = any_sample();
    b.idx  = idx[dfir_pkg::TIDX_W-1:0];
    b.tap  = v;
    return b;
  endfunction

  task automatic send_beat(fir_beat_t b);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= b.func;
    in_sample_re <= b.re;
    in_sample_im <= b.im;
    in_tap_index <= b.idx;
    in_tap_value <= b.tap;
    if (b.func == dfir_pkg::FUNC_LOAD) tap_loaded[b.idx] = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_beat(b);
    @(negedge clk);
  endtask

  // no tap inside the active range may be read before it was loaded
  task automatic ensure_taps(int count);
    for (int i = 0; i < count && i < dfir_pkg::MAX_TAPS; i++) begin
      if (!tap_loaded[i]) send_beat(load_beat(i, any_tap()));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(logic [dfir_pkg::CFG_IDX_W-1:0] idx, logic [dfir_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_settings(int dec_v, int taps_v, bit cplx_v);
    put_reg(dfir_pkg::CFG_DECIMATION, dec_v[dfir_pkg::CFG_W-1:0]);
    put_reg(dfir_pkg::CFG_NUM_TAPS, taps_v[dfir_pkg::CFG_W-1:0]);
    put_reg(dfir_pkg::CFG_COMPLEX, {{(dfir_pkg::CFG_W-1){1'b0}}, cplx_v});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int items;
    int len;
    int dec_v;
    int taps_v;
    bit cplx_v;
    board        = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = dfir_pkg::CFG_DECIMATION;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_func      = dfir_pkg::FUNC_PUSH;
    in_sample_re = '0;
    in_sample_im = '0;
    in_tap_index = '0;
    in_tap_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, full-scale samples
    send_beat(load_beat(0, 16'sh7fff));
    send_beat(push_beat(16'sh7fff, 16'sh1234));
    send_beat(push_beat(16'sh8000, 16'sh0000));
    send_beat(push_beat(16'sh0000, 16'sh7fff));
    send_beat(push_beat(16'sh0001, 16'sh8000));
    send_beat(push_beat(16'shffff, 16'shffff));
    settle();

    // decimation zero, complex, clipping both ways
    apply_settings(0, 3, 1'b1);
    for (int i = 0; i < 3; i++) send_beat(load_beat(i, 16'sh8000));
    send_beat(push_beat(16'sh8000, 16'sh8000));
    send_beat(push_beat(16'sh8000, 16'sh7fff));
    send_beat(push_beat(16'sh7fff, 16'sh8000));
    send_beat(push_beat(16'sh7fff, 16'sh7fff));
    settle();

    // rounding at the half step
    apply_settings(1, 1, 1'b0);
    send_beat(load_beat(0, 16'sh0001));
    send_beat(push_beat(16'sh4000, any_sample()));
    send_beat(push_beat(16'shc000, any_sample()));
    send_beat(push_beat(16'shbfff, any_sample()));
    send_beat(push_beat(16'sh3fff, any_sample()));
    settle();

    // empty tap set, phase left mid-cycle
    apply_settings(255, 0, 1'b1);
    repeat (3) send_beat(push_beat(any_sample(), any_sample()));
    settle();

    // tap count above the maximum, phase beyond the new decimation
    apply_settings(2, 127, 1'b1);
    ensure_taps(dfir_pkg::MAX_TAPS);
    repeat (4) send_beat(push_beat(any_sample(), any_sample()));
    settle();

    items = 0;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: dec_v = 0;
        1: dec_v = 255;
        2: dec_v = $urandom_range(1, 255);
        default: dec_v = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: taps_v = 0;
        1: taps_v = dfir_pkg::MAX_TAPS;
        2: taps_v = $urandom_range(dfir_pkg::MAX_TAPS + 1, 127);
        3: taps_v = $urandom_range(1, dfir_pkg::MAX_TAPS);
        default: taps_v = $urandom_range(1, 8);
      endcase
      cplx_v = 1'($urandom_range(0, 1));
      idling = (items < RANDOM_ITEMS - 120);
      apply_settings(dec_v, taps_v, cplx_v);
      ensure_taps(taps_v);
      len = $urandom_range(20, 90);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(load_beat($urandom_range(0, dfir_pkg::MAX_TAPS - 1), any_tap()));
        else
          send_beat(push_beat(any_sample(), any_sample()));
      end
      items += len;
      settle();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dfir_pkg.sv
hw/rtl/dfir_ram.sv
hw/rtl/dfir_ctrl.sv
hw/rtl/dfir_datapath.sv
hw/rtl/decimating_fir_filter.sv
dv/testbench.sv
